// ===== rtl/next_occurrence_date_calc_macros.svh =====
// Assertion helpers for the date calculator
`ifndef NEXT_OCCURRENCE_DATE_CALC_MACROS_SVH
`define NEXT_OCCURRENCE_DATE_CALC_MACROS_SVH

// Same-cycle implication, quiet while reset is held
`define NDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is held
`define NDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ndc_pkg.sv =====
package ndc_pkg;

  localparam int unsigned YR_W   = 13;  // year with headroom for the wrap into the next year
  localparam int unsigned YDAY_W = 9;
  localparam int unsigned MULB_W = 17;
  localparam int unsigned PROD_W = YR_W + MULB_W;
  localparam int unsigned RECIP_SHIFT = 19;

  // floor(x / 100) == (x * DIV100_RECIP) >> 19 for x below 43690
  localparam logic [MULB_W-1:0] DIV100_RECIP = 17'd5243;
  // floor(x / 7) == (x * DIV7_RECIP) >> 19 for x below 104857
  localparam logic [MULB_W-1:0] DIV7_RECIP   = 17'd74899;

  localparam logic [1:0] MODE_TIME  = 2'd0;
  localparam logic [1:0] MODE_WDAY  = 2'd1;
  localparam logic [1:0] MODE_DATE  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;
  localparam logic [3:0] MON_DEC = 4'd11;

  typedef enum logic {
    MUL_DIV100,
    MUL_DIV7
  } mul_op_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      MON_FEB:                            n = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
      default:                            n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/next_occurrence_date_calc.sv =====
// Channel   | Handshake         | Beat fields
// ----------+-------------------+-----------------------------------------------
// request   | start / busy      | in_now_*, in_req_*, in_next_week
// result    | out_valid strobe  | out_year, out_month, out_mday, out_yday,
//           |                   | out_wday, out_hour, out_min, out_bad_request
//
// Busy stays high while a valid request runs a leap test (multiply, check), a day-of-year
// walk of one month at a time, a weekday pass (divide, sum, multiply, modulo), a wrap check
// (with a new leap test if the year moves on) and a month split. Month-and-day requests take
// a new leap test if the year moves on, a second walk and weekday pass in place of both.
// An invalid request is answered in the next cycle without raising busy. The receiver cannot
// stall: each result is strobed for one cycle as busy drops. Reset clears sequencer and strobe.
`include "next_occurrence_date_calc_macros.svh"

module next_occurrence_date_calc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_now_year,
  input  logic [3:0]  in_now_month,
  input  logic [4:0]  in_now_mday,
  input  logic [4:0]  in_now_hour,
  input  logic [5:0]  in_now_min,
  input  logic [4:0]  in_req_hour,
  input  logic [5:0]  in_req_min,
  input  logic [1:0]  in_req_mode,
  input  logic [3:0]  in_req_month,
  input  logic [4:0]  in_req_mday,
  input  logic [2:0]  in_req_wday,
  input  logic        in_next_week,
  output logic        out_valid,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_mday,
  output logic [8:0]  out_yday,
  output logic [2:0]  out_wday,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_min,
  output logic        out_bad_request
);

  localparam int unsigned YR_W   = ndc_pkg::YR_W;
  localparam int unsigned YDAY_W = ndc_pkg::YDAY_W;
  localparam int unsigned PROD_W = ndc_pkg::PROD_W;
  localparam int unsigned SH     = ndc_pkg::RECIP_SHIFT;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LEAP_MUL = 4'd1;
  localparam logic [3:0] S_LEAP_CHK = 4'd2;
  localparam logic [3:0] S_DOY      = 4'd3;
  localparam logic [3:0] S_WD_DIV   = 4'd4;
  localparam logic [3:0] S_WD_SUM   = 4'd5;
  localparam logic [3:0] S_WD_MUL   = 4'd6;
  localparam logic [3:0] S_WD_MOD   = 4'd7;
  localparam logic [3:0] S_ADJ      = 4'd8;
  localparam logic [3:0] S_SPLIT    = 4'd9;

  localparam logic PH_NOW = 1'b0;
  localparam logic PH_TGT = 1'b1;

  logic [3:0]        state_r, state_nxt;
  logic              ph_r, ph_nxt;
  logic [YR_W-1:0]   yr_r, yr_nxt;
  logic              leap_r, leap_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [3:0]        lim_r, lim_nxt;
  logic [YDAY_W-1:0] acc_r, acc_nxt;
  logic [YDAY_W-1:0] rem_r, rem_nxt;
  logic [YR_W-1:0]   sum_r, sum_nxt;
  logic [2:0]        nwday_r, nwday_nxt;
  logic [2:0]        wday_r, wday_nxt;

  logic [3:0] nmo_r, nmo_nxt;
  logic [4:0] nd_r, nd_nxt;
  logic [4:0] nh_r, nh_nxt;
  logic [5:0] nmi_r, nmi_nxt;
  logic [4:0] rh_r, rh_nxt;
  logic [5:0] rmi_r, rmi_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [3:0] rmo_r, rmo_nxt;
  logic [4:0] rd_r, rd_nxt;
  logic [2:0] rw_r, rw_nxt;
  logic       wk_r, wk_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_year_r, out_year_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [4:0]  out_mday_r, out_mday_nxt;
  logic [8:0]  out_yday_r, out_yday_nxt;
  logic [2:0]  out_wday_r, out_wday_nxt;
  logic [4:0]  out_hour_r, out_hour_nxt;
  logic [5:0]  out_min_r, out_min_nxt;
  logic        out_bad_r, out_bad_nxt;

  ndc_pkg::mul_op_t   mul_op;
  logic [YR_W-1:0]    mul_a;
  logic [PROD_W-1:0]  prod_r;

  // request decode
  logic [3:0] in_nmo_c, in_rmo_c;
  logic [4:0] in_nd_c;
  logic [2:0] in_rw_c;
  logic [1:0] in_mode_c;
  logic       in_bad;

  // datapath terms
  logic [YR_W-1:0]   p_yr;
  logic [7:0]        c100;
  logic [5:0]        q400;
  logic [9:0]        six_c;
  logic [10:0]       q_small;
  logic [YR_W-1:0]   q_times;
  logic              leap_c;
  logic [2:0]        wd_res;
  logic [4:0]        ml;
  logic              late_time, late_date;
  logic [3:0]        wdiff;
  logic [2:0]        wstep;
  logic [YDAY_W-1:0] yday_a;
  logic [YDAY_W-1:0] year_len;
  logic [2:0]        wday_a;

  ndc_alu u_alu (
    .clk    (clk),
    .op     (mul_op),
    .a      (mul_a),
    .prod_r (prod_r)
  );

  always_comb begin
    in_nmo_c  = (in_now_month > ndc_pkg::MON_DEC) ? ndc_pkg::MON_DEC : in_now_month;
    in_rmo_c  = (in_req_month > ndc_pkg::MON_DEC) ? ndc_pkg::MON_DEC : in_req_month;
    in_nd_c   = (in_now_mday == 5'd0) ? 5'd1 : in_now_mday;
    in_rw_c   = (in_req_wday == 3'd7) ? 3'd0 : in_req_wday;
    in_mode_c = (in_req_mode == ndc_pkg::MODE_SPARE) ? ndc_pkg::MODE_TIME : in_req_mode;
    in_bad    = (in_req_hour > 5'd23) || (in_req_min > 6'd59) ||
                (in_mode_c == ndc_pkg::MODE_DATE && in_req_mday == 5'd0);
  end

  always_comb begin
    p_yr    = yr_r + YR_W'(399);
    c100    = prod_r[SH+7:SH];
    q400    = 6'((9'(c100) + 9'd3) >> 2);
    six_c   = 10'({c100, 2'b00}) + 10'({c100, 1'b0});
    q_small = prod_r[SH+10:SH];
    // q*100 for the century test, and q*7 for the weekday remainder
    q_times = (state_r == S_LEAP_CHK)
            ? YR_W'({q_small, 6'b0}) + YR_W'({q_small, 5'b0}) + YR_W'({q_small, 2'b0})
            : YR_W'({q_small, 3'b0}) - YR_W'(q_small);
    leap_c  = (yr_r[1:0] == 2'b00) && ((q_times != yr_r) || (q_small[1:0] == 2'b00));
    wd_res  = 3'(sum_r - q_times);
    ml      = ndc_pkg::month_len(mon_r, leap_r);

    late_time = (rh_r < nh_r) || (rh_r == nh_r && rmi_r <= nmi_r);
    late_date = (rmo_r < nmo_r) || (rmo_r == nmo_r && rd_r < nd_r);

    wdiff = 4'(rw_r) + 4'd7 - 4'(nwday_r);
    wstep = (wdiff >= 4'd7) ? 3'(wdiff - 4'd7) : 3'(wdiff);
    if (mode_r == ndc_pkg::MODE_WDAY) begin
      yday_a = acc_r + YDAY_W'(wstep) +
               (((late_time && rw_r == nwday_r) || wk_r) ? YDAY_W'(7) : YDAY_W'(0));
      wday_a = rw_r;
    end else if (wk_r) begin
      yday_a = acc_r + YDAY_W'(7);
      wday_a = nwday_r;
    end else if (late_time) begin
      yday_a = acc_r + YDAY_W'(1);
      wday_a = (nwday_r == 3'd6) ? 3'd0 : nwday_r + 3'd1;
    end else begin
      yday_a = acc_r;
      wday_a = nwday_r;
    end
    year_len = leap_r ? YDAY_W'(366) : YDAY_W'(365);
  end

  always_comb begin
    unique case (state_r)
      S_WD_DIV: begin
        mul_op = ndc_pkg::MUL_DIV100;
        mul_a  = p_yr + YR_W'(100);
      end
      S_WD_MUL: begin
        mul_op = ndc_pkg::MUL_DIV7;
        mul_a  = sum_r;
      end
      default: begin
        mul_op = ndc_pkg::MUL_DIV100;
        mul_a  = yr_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    yr_nxt    = yr_r;
    leap_nxt  = leap_r;
    mon_nxt   = mon_r;
    lim_nxt   = lim_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    nwday_nxt = nwday_r;
    wday_nxt  = wday_r;
    nmo_nxt   = nmo_r;
    nd_nxt    = nd_r;
    nh_nxt    = nh_r;
    nmi_nxt   = nmi_r;
    rh_nxt    = rh_r;
    rmi_nxt   = rmi_r;
    mode_nxt  = mode_r;
    rmo_nxt   = rmo_r;
    rd_nxt    = rd_r;
    rw_nxt    = rw_r;
    wk_nxt    = wk_r;

    out_valid_nxt = 1'b0;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_mday_nxt  = out_mday_r;
    out_yday_nxt  = out_yday_r;
    out_wday_nxt  = out_wday_r;
    out_hour_nxt  = out_hour_r;
    out_min_nxt   = out_min_r;
    out_bad_nxt   = out_bad_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_bad) begin
            out_valid_nxt = 1'b1;
            out_year_nxt  = '0;
            out_month_nxt = '0;
            out_mday_nxt  = '0;
            out_yday_nxt  = '0;
            out_wday_nxt  = '0;
            out_hour_nxt  = '0;
            out_min_nxt   = '0;
            out_bad_nxt   = 1'b1;
          end else begin
            state_nxt = S_LEAP_MUL;
            ph_nxt    = PH_NOW;
            yr_nxt    = YR_W'(in_now_year);
            mon_nxt   = '0;
            lim_nxt   = in_nmo_c;
            acc_nxt   = YDAY_W'(in_nd_c) - YDAY_W'(1);
            nmo_nxt   = in_nmo_c;
            nd_nxt    = in_nd_c;
            nh_nxt    = in_now_hour;
            nmi_nxt   = in_now_min;
            rh_nxt    = in_req_hour;
            rmi_nxt   = in_req_min;
            mode_nxt  = in_mode_c;
            rmo_nxt   = in_rmo_c;
            rd_nxt    = in_req_mday;
            rw_nxt    = in_rw_c;
            wk_nxt    = in_next_week;
          end
        end
      end
      S_LEAP_MUL: state_nxt = S_LEAP_CHK;
      S_LEAP_CHK: begin
        leap_nxt = leap_c;
        if (ph_r == PH_NOW || mode_r == ndc_pkg::MODE_DATE) begin
          state_nxt = S_DOY;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_DOY: begin
        // add one whole month per cycle
        if (mon_r < lim_r) begin
          acc_nxt = acc_r + YDAY_W'(ml);
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = S_WD_DIV;
        end
      end
      S_WD_DIV: state_nxt = S_WD_SUM;
      S_WD_SUM: begin
        sum_nxt   = p_yr + YR_W'(acc_r) + YR_W'((p_yr + YR_W'(4)) >> 2) +
                    YR_W'(q400) + YR_W'(six_c);
        state_nxt = S_WD_MUL;
      end
      S_WD_MUL: state_nxt = S_WD_MOD;
      S_WD_MOD: begin
        if (ph_r == PH_TGT) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = yr_r[11:0];
          out_month_nxt = rmo_r;
          out_mday_nxt  = rd_r;
          out_yday_nxt  = acc_r;
          out_wday_nxt  = wd_res;
          out_hour_nxt  = rh_r;
          out_min_nxt   = rmi_r;
          out_bad_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          nwday_nxt = wd_res;
          if (mode_r == ndc_pkg::MODE_DATE) begin
            ph_nxt  = PH_TGT;
            yr_nxt  = yr_r + YR_W'(late_date);
            mon_nxt = '0;
            lim_nxt = rmo_r;
            acc_nxt = YDAY_W'(rd_r) - YDAY_W'(1);
            // leap flag only changes if the year moves on
            state_nxt = late_date ? S_LEAP_MUL : S_DOY;
          end else begin
            state_nxt = S_ADJ;
          end
        end
      end
      S_ADJ: begin
        wday_nxt = wday_a;
        mon_nxt  = '0;
        if (yday_a >= year_len) begin
          acc_nxt   = yday_a - year_len;
          rem_nxt   = yday_a - year_len;
          yr_nxt    = yr_r + YR_W'(1);
          ph_nxt    = PH_TGT;
          state_nxt = S_LEAP_MUL;
        end else begin
          acc_nxt   = yday_a;
          rem_nxt   = yday_a;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        // peel off one month per cycle until the day lands inside it or December is reached
        if (mon_r < ndc_pkg::MON_DEC && rem_r >= YDAY_W'(ml)) begin
          rem_nxt = rem_r - YDAY_W'(ml);
          mon_nxt = mon_r + 4'd1;
        end else begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = yr_r[11:0];
          out_month_nxt = mon_r;
          out_mday_nxt  = 5'(rem_r) + 5'd1;
          out_yday_nxt  = acc_r;
          out_wday_nxt  = wday_r;
          out_hour_nxt  = rh_r;
          out_min_nxt   = rmi_r;
          out_bad_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r        <= ph_nxt;
    yr_r        <= yr_nxt;
    leap_r      <= leap_nxt;
    mon_r       <= mon_nxt;
    lim_r       <= lim_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    sum_r       <= sum_nxt;
    nwday_r     <= nwday_nxt;
    wday_r      <= wday_nxt;
    nmo_r       <= nmo_nxt;
    nd_r        <= nd_nxt;
    nh_r        <= nh_nxt;
    nmi_r       <= nmi_nxt;
    rh_r        <= rh_nxt;
    rmi_r       <= rmi_nxt;
    mode_r      <= mode_nxt;
    rmo_r       <= rmo_nxt;
    rd_r        <= rd_nxt;
    rw_r        <= rw_nxt;
    wk_r        <= wk_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_mday_r  <= out_mday_nxt;
    out_yday_r  <= out_yday_nxt;
    out_wday_r  <= out_wday_nxt;
    out_hour_r  <= out_hour_nxt;
    out_min_r   <= out_min_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_year        = out_year_r;
  assign out_month       = out_month_r;
  assign out_mday        = out_mday_r;
  assign out_yday        = out_yday_r;
  assign out_wday        = out_wday_r;
  assign out_hour        = out_hour_r;
  assign out_min         = out_min_r;
  assign out_bad_request = out_bad_r;

  logic bad_blank;
  logic date_sane;

  assign bad_blank = (out_year == 12'd0) && (out_mday == 5'd0) && (out_yday == 9'd0);
  assign date_sane = (out_mday != 5'd0) && (out_month <= ndc_pkg::MON_DEC) &&
                     (out_wday != 3'd7);

  `NDC_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "beat dropped")
  `NDC_ASSERT_NOW(a_strobe_idle, busy, !out_valid, "result strobed while sequencer running")
  `NDC_ASSERT_NOW(a_bad_zero, out_valid && out_bad_request, bad_blank, "date on rejected beat")
  `NDC_ASSERT_NOW(a_good_date, out_valid && !out_bad_request, date_sane, "date out of range")

endmodule

// ===== rtl/ndc_alu.sv =====
module ndc_alu (
  input  logic                              clk,
  input  ndc_pkg::mul_op_t                  op,
  input  logic [ndc_pkg::YR_W-1:0]          a,
  output logic [ndc_pkg::PROD_W-1:0]        prod_r
);

  logic [ndc_pkg::MULB_W-1:0] b;
  logic [ndc_pkg::PROD_W-1:0] prod_nxt;

  always_comb begin
    unique case (op)
      ndc_pkg::MUL_DIV100: b = ndc_pkg::DIV100_RECIP;
      ndc_pkg::MUL_DIV7:   b = ndc_pkg::DIV7_RECIP;
      default:             b = ndc_pkg::DIV100_RECIP;
    endcase
    prod_nxt = ndc_pkg::PROD_W'(a) * ndc_pkg::PROD_W'(b);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANDOM_REQUESTS = 1350;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned DRAIN_CYCLES    = 64;

  localparam int unsigned NORMAL_MONTH_DAYS [12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [11:0] now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_mday;
    logic [4:0]  now_hour;
    logic [5:0]  now_min;
    logic [4:0]  req_hour;
    logic [5:0]  req_min;
    logic [1:0]  req_mode;
    logic [3:0]  req_month;
    logic [4:0]  req_mday;
    logic [2:0]  req_wday;
    logic        next_week;
  } date_req_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [8:0]  yday;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic        bad;
  } sched_t;

  typedef struct packed {
    date_req_t req;
    logic      has_fixed;
    sched_t    fixed;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [11:0] in_now_year;
  logic [3:0]  in_now_month;
  logic [4:0]  in_now_mday;
  logic [4:0]  in_now_hour;
  logic [5:0]  in_now_min;
  logic [4:0]  in_req_hour;
  logic [5:0]  in_req_min;
  logic [1:0]  in_req_mode;
  logic [3:0]  in_req_month;
  logic [4:0]  in_req_mday;
  logic [2:0]  in_req_wday;
  logic        in_next_week;
  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_mday;
  logic [8:0]  out_yday;
  logic [2:0]  out_wday;
  logic [4:0]  out_hour;
  logic [5:0]  out_min;
  logic        out_bad_request;

  sched_t        pending_sched[$];
  directed_row_t directed_rows[$];
  int unsigned   fault_count;
  int unsigned   cycle_count;

  next_occurrence_date_calc DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_now_year     (in_now_year),
    .in_now_month    (in_now_month),
    .in_now_mday     (in_now_mday),
    .in_now_hour     (in_now_hour),
    .in_now_min      (in_now_min),
    .in_req_hour     (in_req_hour),
    .in_req_min      (in_req_min),
    .in_req_mode     (in_req_mode),
    .in_req_month    (in_req_month),
    .in_req_mday     (in_req_mday),
    .in_req_wday     (in_req_wday),
    .in_next_week    (in_next_week),
    .out_valid       (out_valid),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_mday        (out_mday),
    .out_yday        (out_yday),
    .out_wday        (out_wday),
    .out_hour        (out_hour),
    .out_min         (out_min),
    .out_bad_request (out_bad_request)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mon);
    int unsigned n;
    n = NORMAL_MONTH_DAYS[mon > ndc_pkg::MON_DEC ? ndc_pkg::MON_DEC : mon];
    if (mon == ndc_pkg::MON_FEB && leap_year(yr)) n++;
    return n;
  endfunction

  function automatic int unsigned ordinal_day(input int unsigned yr, input int unsigned mon,
                                              input int unsigned mday);
    int unsigned acc;
    acc = mday - 1;
    for (int unsigned i = 0; i < mon; i++) acc += days_in_month(yr, i);
    return acc;
  endfunction

  // closed rule for the weekday of 1 January, on the year before shifted by a whole 400-year cycle
  function automatic int unsigned weekday_of(input int unsigned yr, input int unsigned yday);
    int unsigned q;
    int unsigned jan1;
    q = yr + 399;
    jan1 = (1 + 5 * (q % 4) + 4 * (q % 100) + 6 * (q % 400)) % 7;
    return (jan1 + yday) % 7;
  endfunction

  function automatic sched_t predict_schedule(input date_req_t r);
    int unsigned yr, nmo, nd, nh, nmi, rh, rmi, rmo, rd, rw, mode;
    int unsigned nyday, nwday, yday, wday, mon, mday, len;
    bit late, bad;
    sched_t res;
    yr   = r.now_year;
    nmo  = r.now_month > ndc_pkg::MON_DEC ? ndc_pkg::MON_DEC : r.now_month;
    nd   = r.now_mday == 0 ? 1 : r.now_mday;
    nh   = r.now_hour;
    nmi  = r.now_min;
    rh   = r.req_hour;
    rmi  = r.req_min;
    rmo  = r.req_month > ndc_pkg::MON_DEC ? ndc_pkg::MON_DEC : r.req_month;
    rd   = r.req_mday;
    rw   = r.req_wday > 6 ? 0 : r.req_wday;
    mode = r.req_mode == ndc_pkg::MODE_SPARE ? ndc_pkg::MODE_TIME : r.req_mode;
    res  = '0;

    bad = (rh > 23) || (rmi > 59) || (mode == ndc_pkg::MODE_DATE && rd == 0);
    if (bad) begin
      res.bad = 1'b1;
      return res;
    end

    nyday = ordinal_day(yr, nmo, nd);
    nwday = weekday_of(yr, nyday);

    if (mode == ndc_pkg::MODE_DATE) begin
      late = (rmo < nmo) || (rmo == nmo && rd < nd);
      if (late) yr++;
      mon  = rmo;
      mday = rd;
      yday = ordinal_day(yr, rmo, rd);
      wday = weekday_of(yr, yday);
    end else begin
      late = (rh < nh) || (rh == nh && rmi <= nmi);
      yday = nyday;
      if (mode == ndc_pkg::MODE_WDAY) begin
        yday += (rw + 7 - nwday) % 7;
        wday = rw;
        if ((late && rw == nwday) || r.next_week) yday += 7;
      end else begin
        wday = nwday;
        if (r.next_week) begin
          yday += 7;
        end else if (late) begin
          yday++;
          wday = (wday + 1) % 7;
        end
      end
      // wrap into the next year at most once
      len = leap_year(yr) ? 366 : 365;
      if (yday >= len) begin
        yday -= len;
        yr++;
      end
      mon  = 0;
      mday = yday;
      while (mon < ndc_pkg::MON_DEC && mday >= days_in_month(yr, mon)) begin
        mday -= days_in_month(yr, mon);
        mon++;
      end
      mday++;
    end

    res.year  = yr[11:0];
    res.month = mon[3:0];
    res.mday  = mday[4:0];
    res.yday  = yday[8:0];
    res.wday  = wday[2:0];
    res.hour  = rh[4:0];
    res.min   = rmi[5:0];
    return res;
  endfunction

  function automatic date_req_t mk_req(input int unsigned y, input int unsigned mo,
                                       input int unsigned d, input int unsigned h,
                                       input int unsigned mi, input int unsigned rh,
                                       input int unsigned rmi, input logic [1:0] mode,
                                       input int unsigned rmo, input int unsigned rd,
                                       input int unsigned rw, input bit nw);
    date_req_t r;
    r.now_year  = y[11:0];
    r.now_month = mo[3:0];
    r.now_mday  = d[4:0];
    r.now_hour  = h[4:0];
    r.now_min   = mi[5:0];
    r.req_hour  = rh[4:0];
    r.req_min   = rmi[5:0];
    r.req_mode  = mode;
    r.req_month = rmo[3:0];
    r.req_mday  = rd[4:0];
    r.req_wday  = rw[2:0];
    r.next_week = nw;
    return r;
  endfunction

  function automatic date_req_t random_request();
    date_req_t   r;
    int unsigned pick;
    r.now_year  = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(1970, 2999));
    r.now_month = ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
    r.now_mday  = 5'($urandom_range(1, days_in_month(r.now_year, r.now_month)));
    if ($urandom_range(19) == 0) r.now_mday = 5'($urandom);
    // lean on the last days of the year to exercise the wrap
    if ($urandom_range(9) == 0) begin
      r.now_month = ndc_pkg::MON_DEC;
      r.now_mday  = 5'($urandom_range(25, 31));
    end
    r.now_hour  = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    r.now_min   = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    r.req_hour  = ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    r.req_min   = ($urandom_range(19) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    if ($urandom_range(6) == 0) begin
      r.req_hour = r.now_hour;
      r.req_min  = r.now_min;
    end
    pick = $urandom_range(99);
    r.req_mode  = pick < 30 ? ndc_pkg::MODE_TIME :
                  pick < 60 ? ndc_pkg::MODE_WDAY :
                  pick < 92 ? ndc_pkg::MODE_DATE : ndc_pkg::MODE_SPARE;
    r.req_month = ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
    if ($urandom_range(4) == 0) r.req_month = r.now_month;
    r.req_mday  = 5'($urandom_range(1, days_in_month(r.now_year, r.req_month)));
    if ($urandom_range(4) == 0) r.req_mday = r.now_mday + 5'($urandom_range(0, 2)) - 5'd1;
    pick = $urandom_range(99);
    if (pick < 3) r.req_mday = 5'd0;
    else if (pick < 8) r.req_mday = 5'($urandom);
    r.req_wday  = 3'($urandom_range(0, 7));
    r.next_week = ($urandom_range(9) < 3);
    return r;
  endfunction

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_request(input date_req_t r, input bit use_fixed, input sched_t fixed,
                              input bit may_idle);
    int unsigned gap;
    gap = 0;
    if (may_idle && $urandom_range(99) < 20)
      gap = $urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 80);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_now_year  <= r.now_year;
    in_now_month <= r.now_month;
    in_now_mday  <= r.now_mday;
    in_now_hour  <= r.now_hour;
    in_now_min   <= r.now_min;
    in_req_hour  <= r.req_hour;
    in_req_min   <= r.req_min;
    in_req_mode  <= r.req_mode;
    in_req_month <= r.req_month;
    in_req_mday  <= r.req_mday;
    in_req_wday  <= r.req_wday;
    in_next_week <= r.next_week;
    // hold the beat until the block is free to take it
    do @(posedge clk); while (busy !== 1'b0);
    pending_sched.push_back(use_fixed ? fixed : predict_schedule(r));
  endtask

  always @(posedge clk) begin : result_check
    sched_t got;
    sched_t want;
    bit     ok;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      got = {out_year, out_month, out_mday, out_yday, out_wday, out_hour, out_min,
             out_bad_request};
      if (pending_sched.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %h", $time, got);
        fault_count++;
      end else begin
        want = pending_sched.pop_front();
        ok = field_ok("out_year", want.year, got.year)
           & field_ok("out_month", want.month, got.month)
           & field_ok("out_mday", want.mday, got.mday)
           & field_ok("out_yday", want.yday, got.yday)
           & field_ok("out_wday", want.wday, got.wday)
           & field_ok("out_hour", want.hour, got.hour)
           & field_ok("out_min", want.min, got.min)
           & field_ok("out_bad_request", want.bad, got.bad);
        if (!ok) fault_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    sched_t bad_sched;
    fault_count  = 0;
    cycle_count  = 0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_now_year  <= '0;
    in_now_month <= '0;
    in_now_mday  <= '0;
    in_now_hour  <= '0;
    in_now_min   <= '0;
    in_req_hour  <= '0;
    in_req_min   <= '0;
    in_req_mode  <= ndc_pkg::MODE_TIME;
    in_req_month <= '0;
    in_req_mday  <= '0;
    in_req_wday  <= '0;
    in_next_week <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    bad_sched     = '0;
    bad_sched.bad = 1'b1;
    // invalid hour, invalid minute, zero month day, every field at its top
    directed_rows.push_back({mk_req(2024, 0, 1, 10, 0, 24, 0, ndc_pkg::MODE_TIME, 0, 1, 0, 0),
                             1'b1, bad_sched});
    directed_rows.push_back({mk_req(2024, 5, 15, 10, 0, 12, 60, ndc_pkg::MODE_WDAY, 0, 1, 3,
                                    0),
                             1'b1, bad_sched});
    directed_rows.push_back({mk_req(2024, 5, 15, 10, 0, 12, 0, ndc_pkg::MODE_DATE, 6, 0, 0,
                                    0),
                             1'b1, bad_sched});
    directed_rows.push_back({mk_req(4095, 15, 31, 31, 63, 31, 63, ndc_pkg::MODE_SPARE,
                                    15, 31, 7, 1),
                             1'b1, bad_sched});
    // later today, and midnight rolling over into a new year
    directed_rows.push_back({mk_req(2024, 0, 1, 10, 0, 12, 30, ndc_pkg::MODE_TIME, 0, 1, 0, 0),
                             1'b1, sched_t'({12'd2024, 4'd0, 5'd1, 9'd0, 3'd1, 5'd12, 6'd30,
                                             1'b0})});
    directed_rows.push_back({mk_req(2023, 11, 31, 23, 59, 0, 0, ndc_pkg::MODE_TIME, 0, 1, 0,
                                    0),
                             1'b1, sched_t'({12'd2024, 4'd0, 5'd1, 9'd0, 3'd1, 5'd0, 6'd0,
                                             1'b0})});
    directed_rows.push_back({mk_req(2023, 6, 14, 8, 30, 8, 30, ndc_pkg::MODE_TIME, 0, 1, 0, 0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2023, 11, 28, 12, 0, 13, 0, ndc_pkg::MODE_TIME, 0, 1, 0,
                                    1),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2024, 0, 1, 10, 0, 11, 0, ndc_pkg::MODE_WDAY, 0, 1, 1, 0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2024, 0, 1, 10, 0, 9, 0, ndc_pkg::MODE_WDAY, 0, 1, 1, 0),
                             1'b0, sched_t'('0)});
    // weekday code 7 stands for Sunday
    directed_rows.push_back({mk_req(2024, 1, 29, 0, 0, 23, 59, ndc_pkg::MODE_WDAY, 0, 1, 7, 1),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2024, 5, 15, 10, 0, 12, 0, ndc_pkg::MODE_DATE, 2, 1, 0, 0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2024, 5, 15, 10, 0, 12, 0, ndc_pkg::MODE_DATE, 5, 14, 0,
                                    1),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2024, 5, 15, 10, 0, 9, 0, ndc_pkg::MODE_DATE, 5, 15, 0, 0),
                             1'b0, sched_t'('0)});
    // day past the end of February passes through unchecked
    directed_rows.push_back({mk_req(2023, 0, 10, 10, 0, 9, 0, ndc_pkg::MODE_DATE, 1, 31, 0, 0),
                             1'b0, sched_t'('0)});
    // year overflow, in date mode and through the wrap
    directed_rows.push_back({mk_req(4095, 11, 31, 10, 0, 9, 0, ndc_pkg::MODE_DATE, 0, 1, 0, 0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(4095, 11, 31, 23, 59, 0, 0, ndc_pkg::MODE_TIME, 0, 1, 0,
                                    0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(0, 1, 29, 0, 0, 0, 0, ndc_pkg::MODE_TIME, 0, 1, 0, 0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(1900, 1, 28, 23, 0, 22, 0, ndc_pkg::MODE_TIME, 0, 1, 0, 0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2000, 11, 31, 12, 0, 12, 0, ndc_pkg::MODE_WDAY, 0, 1, 3,
                                    0),
                             1'b0, sched_t'('0)});
    // out-of-range months clamp to December, zero current day to the first
    directed_rows.push_back({mk_req(2100, 15, 0, 5, 5, 6, 6, ndc_pkg::MODE_DATE, 14, 31, 0, 0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(1970, 0, 0, 31, 63, 23, 59, ndc_pkg::MODE_SPARE, 0, 1, 0,
                                    0),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2999, 11, 31, 0, 0, 23, 59, ndc_pkg::MODE_WDAY, 0, 1, 6,
                                    1),
                             1'b0, sched_t'('0)});
    directed_rows.push_back({mk_req(2024, 2, 1, 31, 0, 23, 59, ndc_pkg::MODE_SPARE, 0, 1, 0,
                                    0),
                             1'b0, sched_t'('0)});

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].has_fixed, directed_rows[i].fixed,
                   1'b1);

    // a stretch in the middle runs back to back with no idling
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++)
      send_request(random_request(), 1'b0, sched_t'('0), !(n >= 400 && n < 750));

    start <= 1'b0;
    while (pending_sched.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== next_occurrence_date_calc.f =====
+incdir+rtl
rtl/ndc_pkg.sv
rtl/ndc_alu.sv
rtl/next_occurrence_date_calc.sv
tb/testbench.sv
